>>> sv/dcfbc_pkg.sv
// Package for the detection class filter and box clip core.
// Holds field widths, register address codes and the rounding helpers
// shared by the top level and the per-axis modules. No dependencies.
`default_nettype none

package dcfbc_pkg;

  // field widths
  localparam int PROB_W = 17;
  localparam int CX_W   = 18;
  localparam int SZ_W   = 17;
  localparam int DIM_W  = 14;
  localparam int IDX_W  = 8;
  localparam int HIT_W  = 9;
  localparam int PXO_W  = 15;
  localparam int PXS_W  = 14;

  // product widths: size by dimension, signed centre by dimension
  localparam int SD_W = SZ_W + DIM_W;
  localparam int CD_W = CX_W + DIM_W + 1;

  // stream word widths, padded to whole bytes
  localparam int IN_BITS  = PROB_W + 2 * CX_W + 2 * SZ_W;
  localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = IDX_W + PROB_W + HIT_W + 2 * PXO_W + 2 * PXS_W
                            + 2 * CX_W + 2 * SZ_W;
  localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_CLIP   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  // wide signed working value for rounding and saturation
  typedef logic signed [39:0] wide_t;

  // divide by 2^sh, rounding half away from zero (sh >= 1)
  function automatic wide_t rnd_shift(input wide_t v, input int unsigned sh);
    wide_t half;
    wide_t mag;
    wide_t r;
    half = 40'sd1 <<< (sh - 1);
    mag  = (v < 0) ? -v : v;
    r    = (mag + half) >>> sh;
    return (v < 0) ? -r : r;
  endfunction

  // clamp into [lo, hi]
  function automatic wide_t sat(input wide_t v, input wide_t lo, input wide_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

endpackage

`default_nettype wire

>>> sv/dcfbc_clip_axis.sv
// Clips one box axis into the unit range and recomputes centre and size.
// Combinational; uses dcfbc_pkg for widths and rounding helpers.
`default_nettype none

module dcfbc_clip_axis #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clip_en,
  input  logic signed [dcfbc_pkg::CX_W-1:0]  c,
  input  logic        [dcfbc_pkg::SZ_W-1:0]  s,
  output logic signed [dcfbc_pkg::CX_W-1:0]  nc,
  output logic        [dcfbc_pkg::SZ_W-1:0]  ns
);
  import dcfbc_pkg::*;

  localparam wide_t ONE = 40'sd2 <<< FRAC_BITS;

  wide_t c_e, s_e, e1, e2, e1c, e2c, diff, sum, sz;
  wide_t nc_w, ns_w;
  logic  do_clip;

  // edges in doubled precision
  assign c_e = {{(40 - CX_W){c[CX_W-1]}}, c};
  assign s_e = {{(40 - SZ_W){1'b0}}, s};
  assign e1  = (c_e <<< 1) - s_e;
  assign e2  = (c_e <<< 1) + s_e;

  assign do_clip = clip_en && ((e1 < 0) || (e2 > ONE));

  // clamp the edges and rebuild centre and size
  assign e1c  = (e1 < 0) ? '0 : e1;
  assign e2c  = (e2 > ONE) ? ONE : e2;
  assign diff = e2c - e1c;
  assign sum  = e1c + e2c;
  assign sz   = rnd_shift(diff, 1);

  always_comb begin
    if (do_clip) begin
      nc_w = rnd_shift(sum, 2);
      ns_w = (sz < 0) ? '0 : sz;
    end else begin
      nc_w = c_e;
      ns_w = s_e;
    end
  end

  // saturate into the field ranges
  wide_t nc_s, ns_s;
  assign nc_s = sat(nc_w, -40'sd131072, 40'sd131071);
  assign ns_s = sat(ns_w, 40'sd0, 40'sd131071);
  assign nc   = nc_s[CX_W-1:0];
  assign ns   = ns_s[SZ_W-1:0];

endmodule

`default_nettype wire

>>> sv/dcfbc_px_axis.sv
// Finishes pixel scaling of one axis from the registered products.
// Combinational; uses dcfbc_pkg for widths and rounding helpers.
`default_nettype none

module dcfbc_px_axis #(
  parameter int FRAC_BITS = 16
) (
  input  logic        [dcfbc_pkg::SD_W-1:0]  sd,
  input  logic signed [dcfbc_pkg::CD_W-1:0]  cd,
  output logic signed [dcfbc_pkg::PXO_W-1:0] org,
  output logic        [dcfbc_pkg::PXS_W-1:0] size
);
  import dcfbc_pkg::*;

  wide_t sd_e, cd_e, sp, t, org_w, size_w;

  // pixel size, rounded before the origin uses it
  assign sd_e = {{(40 - SD_W){1'b0}}, sd};
  assign cd_e = {{(40 - CD_W){cd[CD_W-1]}}, cd};
  assign sp   = rnd_shift(sd_e, FRAC_BITS);

  // origin from twice the centre less the pixel size
  assign t      = (cd_e <<< 1) - (sp <<< FRAC_BITS);
  assign org_w  = sat(rnd_shift(t, FRAC_BITS + 1), -40'sd16384, 40'sd16383);
  assign size_w = sat(sp, 40'sd0, 40'sd16383);

  assign org  = org_w[PXO_W-1:0];
  assign size = size_w[PXS_W-1:0];

endmodule

`default_nettype wire

>>> sv/detection_class_filter_box_clip_core.sv
// Detection class filter with box clipping and pixel scaling, top level.
// Throughput: one word per cycle on the input while in_tready is high; class words
// update the running best, hit count and index in the cycle they are accepted.
// A result reaches out_tvalid after its last class word through the capture,
// clip, multiply and output register stages.
// Reset (rst_n low, synchronous): class state and pipeline empty, registers
// back to threshold one half, clipping on, 640 by 480.
`default_nettype none

module detection_class_filter_box_clip_core #(
  parameter int MAX_CLASSES = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: class_prob, box_cx, box_cy, box_w, box_h (lowest bit up)
  input  logic [dcfbc_pkg::IN_DW-1:0]      in_tdata,
  input  logic                             in_tlast,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: top_class, best_prob, hit_count, rect_x, rect_y, rect_w, rect_h,
  //        norm_cx, norm_cy, norm_w, norm_h (lowest bit up)
  output logic [dcfbc_pkg::OUT_DW-1:0]     out_tdata,
  // configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dcfbc_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [dcfbc_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [dcfbc_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                             cfg_pready
);
  import dcfbc_pkg::*;

  localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam logic [CW-1:0]     CNT_MAX    = CW'(MAX_CLASSES - 1);
  localparam logic [PROB_W-1:0] THRESH_RST = PROB_W'(64'd1 << (FRAC_BITS - 1));

  // ---------------------------------------------------------------------
  // configuration registers
  logic [PROB_W-1:0] thresh_r;
  logic              clip_en_r;
  logic [DIM_W-1:0]  img_w_r, img_h_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RST;
      clip_en_r <= 1'b1;
      img_w_r   <= DIM_W'(640);
      img_h_r   <= DIM_W'(480);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_THRESH: thresh_r  <= cfg_pwdata[PROB_W-1:0];
        REG_CLIP:   clip_en_r <= cfg_pwdata[0];
        REG_WIDTH:  img_w_r   <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: img_h_r   <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_THRESH: cfg_prdata = {{(DATA_W - PROB_W){1'b0}}, thresh_r};
      REG_CLIP:   cfg_prdata = {{(DATA_W - 1){1'b0}}, clip_en_r};
      REG_WIDTH:  cfg_prdata = {{(DATA_W - DIM_W){1'b0}}, img_w_r};
      REG_HEIGHT: cfg_prdata = {{(DATA_W - DIM_W){1'b0}}, img_h_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // pipeline flow: each stage loads when empty or when the next one loads
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic load_out, load3, load2, load1, in_acc;

  assign load_out  = !out_vld_r || out_tready;
  assign load3     = !s3_vld_r || load_out;
  assign load2     = !s2_vld_r || load3;
  assign load1     = !s1_vld_r || load2;
  assign in_tready = load1;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------
  // running class state
  logic [CW-1:0]     cnt_r, idx_r;
  logic [PROB_W-1:0] best_r;
  logic [HIT_W-1:0]  hits_r;

  logic [PROB_W-1:0] prob;
  logic              hit, better, emit;
  logic [CW-1:0]     cnt_nxt, idx_nxt;
  logic [PROB_W-1:0] best_nxt;
  logic [HIT_W-1:0]  hits_nxt;

  assign prob     = in_tdata[PROB_W-1:0];
  assign hit      = prob >= thresh_r;
  assign better   = hit && (prob > best_r);
  assign hits_nxt = (hit && (hits_r != HIT_MAX)) ? hits_r + 1'b1 : hits_r;
  assign best_nxt = better ? prob : best_r;
  assign idx_nxt  = better ? cnt_r : idx_r;
  assign cnt_nxt  = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign emit     = best_nxt >= thresh_r;

  // advance on every word, clear on the last class
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      idx_r  <= '0;
      best_r <= '0;
      hits_r <= '0;
    end else if (in_acc) begin
      if (in_tlast) begin
        cnt_r  <= '0;
        idx_r  <= '0;
        best_r <= '0;
        hits_r <= '0;
      end else begin
        cnt_r  <= cnt_nxt;
        idx_r  <= idx_nxt;
        best_r <= best_nxt;
        hits_r <= hits_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: capture the finished detection and its box
  logic [IDX_W+CW-1:0]     idx_ext;
  logic [IDX_W-1:0]        s1_idx_r, s2_idx_r, s3_idx_r;
  logic [PROB_W-1:0]       s1_prob_r, s2_prob_r, s3_prob_r;
  logic [HIT_W-1:0]        s1_hits_r, s2_hits_r, s3_hits_r;
  logic signed [CX_W-1:0]  s1_cx_r, s1_cy_r;
  logic [SZ_W-1:0]         s1_w_r, s1_h_r;

  assign idx_ext = {{IDX_W{1'b0}}, idx_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (load1) begin
      s1_vld_r <= in_acc && in_tlast && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_idx_r  <= idx_ext[IDX_W-1:0];
      s1_prob_r <= best_nxt;
      s1_hits_r <= hits_nxt;
      s1_cx_r   <= $signed(in_tdata[PROB_W +: CX_W]);
      s1_cy_r   <= $signed(in_tdata[PROB_W + CX_W +: CX_W]);
      s1_w_r    <= in_tdata[PROB_W + 2 * CX_W +: SZ_W];
      s1_h_r    <= in_tdata[PROB_W + 2 * CX_W + SZ_W +: SZ_W];
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: clip both axes
  logic signed [CX_W-1:0] ncx, ncy, s2_ncx_r, s2_ncy_r;
  logic [SZ_W-1:0]        nw, nh, s2_nw_r, s2_nh_r;

  dcfbc_clip_axis #(.FRAC_BITS(FRAC_BITS)) u_clip_x (
    .clip_en (clip_en_r),
    .c       (s1_cx_r),
    .s       (s1_w_r),
    .nc      (ncx),
    .ns      (nw)
  );

  dcfbc_clip_axis #(.FRAC_BITS(FRAC_BITS)) u_clip_y (
    .clip_en (clip_en_r),
    .c       (s1_cy_r),
    .s       (s1_h_r),
    .nc      (ncy),
    .ns      (nh)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (load2) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_idx_r  <= s1_idx_r;
      s2_prob_r <= s1_prob_r;
      s2_hits_r <= s1_hits_r;
      s2_ncx_r  <= ncx;
      s2_ncy_r  <= ncy;
      s2_nw_r   <= nw;
      s2_nh_r   <= nh;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: multiply by the image dimensions
  logic signed [CD_W-1:0] dim_w_e, dim_h_e, cx_e, cy_e;
  logic signed [CX_W-1:0] s3_ncx_r, s3_ncy_r;
  logic [SZ_W-1:0]        s3_nw_r, s3_nh_r;
  logic [SD_W-1:0]        s3_sdx_r, s3_sdy_r;
  logic signed [CD_W-1:0] s3_cdx_r, s3_cdy_r;

  assign dim_w_e = $signed({{(CD_W - DIM_W){1'b0}}, img_w_r});
  assign dim_h_e = $signed({{(CD_W - DIM_W){1'b0}}, img_h_r});
  assign cx_e    = CD_W'(s2_ncx_r);
  assign cy_e    = CD_W'(s2_ncy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (load3) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_idx_r  <= s2_idx_r;
      s3_prob_r <= s2_prob_r;
      s3_hits_r <= s2_hits_r;
      s3_ncx_r  <= s2_ncx_r;
      s3_ncy_r  <= s2_ncy_r;
      s3_nw_r   <= s2_nw_r;
      s3_nh_r   <= s2_nh_r;
      s3_sdx_r  <= SD_W'(s2_nw_r) * SD_W'(img_w_r);
      s3_sdy_r  <= SD_W'(s2_nh_r) * SD_W'(img_h_r);
      s3_cdx_r  <= cx_e * dim_w_e;
      s3_cdy_r  <= cy_e * dim_h_e;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: round to pixels and hold the result word
  logic signed [PXO_W-1:0] rx, ry;
  logic [PXS_W-1:0]        rw, rh;
  logic [OUT_DW-1:0]       out_data_r;

  dcfbc_px_axis #(.FRAC_BITS(FRAC_BITS)) u_px_x (
    .sd   (s3_sdx_r),
    .cd   (s3_cdx_r),
    .org  (rx),
    .size (rw)
  );

  dcfbc_px_axis #(.FRAC_BITS(FRAC_BITS)) u_px_y (
    .sd   (s3_sdy_r),
    .cd   (s3_cdy_r),
    .org  (ry),
    .size (rh)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {{(OUT_DW - OUT_BITS){1'b0}},
                     s3_nh_r, s3_nw_r, s3_ncy_r, s3_ncx_r,
                     rh, rw, ry, rx,
                     s3_hits_r, s3_prob_r, s3_idx_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> bench/detection_class_filter_box_clip_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for detection_class_filter_box_clip_core: streams class words with
// boxes, predicts each filtered, clipped and scaled detection and checks the result words.
// Depends on dcfbc_pkg and the core.

module detection_class_filter_box_clip_core_tb;
  import dcfbc_pkg::*;

  localparam int     NUM_CLASSES = 256;
  localparam int     FRAC        = 16;
  localparam longint UNIT2       = 131072;  // 1.0 in Q17, the edge domain
  localparam int     SETTLE      = 12;
  localparam int     WATCHDOG    = 4000;

  // input word layout
  localparam int I_CX = PROB_W;
  localparam int I_CY = I_CX + CX_W;
  localparam int I_W  = I_CY + CX_W;
  localparam int I_H  = I_W + SZ_W;

  // result word layout
  localparam int O_PROB = IDX_W;
  localparam int O_HIT  = O_PROB + PROB_W;
  localparam int O_RX   = O_HIT + HIT_W;
  localparam int O_RY   = O_RX + PXO_W;
  localparam int O_RW   = O_RY + PXO_W;
  localparam int O_RH   = O_RW + PXS_W;
  localparam int O_NCX  = O_RH + PXS_W;
  localparam int O_NCY  = O_NCX + CX_W;
  localparam int O_NW   = O_NCY + CX_W;
  localparam int O_NH   = O_NW + SZ_W;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic              last;
    logic [CX_W-1:0]   cx;
    logic [CX_W-1:0]   cy;
    logic [SZ_W-1:0]   w;
    logic [SZ_W-1:0]   h;
  } class_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cls;
    logic [PROB_W-1:0] prob;
    logic [HIT_W-1:0]  hits;
    logic [PXO_W-1:0]  rx;
    logic [PXO_W-1:0]  ry;
    logic [PXS_W-1:0]  rw;
    logic [PXS_W-1:0]  rh;
    logic [CX_W-1:0]   ncx;
    logic [CX_W-1:0]   ncy;
    logic [SZ_W-1:0]   nw;
    logic [SZ_W-1:0]   nh;
  } det_result_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata    = '0;
  logic              in_tlast    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b1;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  detection_class_filter_box_clip_core #(
    .MAX_CLASSES(NUM_CLASSES),
    .FRAC_BITS  (FRAC)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // words waiting to be sent and detections waiting to come out
  class_word_t pending_words[$];
  det_result_t due_detections[$];

  // predictor copy of the registers
  logic [PROB_W-1:0] thr     = 17'd32768;
  logic              clip_on = 1'b1;
  logic [DIM_W-1:0]  img_w   = 14'd640;
  logic [DIM_W-1:0]  img_h   = 14'd480;

  // predictor copy of the running class state
  int                cls_idx  = 0;
  int                best_idx = 0;
  logic [PROB_W-1:0] best_p   = '0;
  int                hit_cnt  = 0;

  int errors     = 0;
  int n_words    = 0;
  int n_dets     = 0;
  int n_checked  = 0;
  int n_settings = 0;
  int idle_cycles = 0;
  logic in_took = 1'b0;

  // ------------------------------------------------------------------ prediction

  // divide by 2^sh, rounding half away from zero
  function automatic longint round_shr(input longint v, input int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // clamp the edges of one axis into the unit range, rebuild centre and size
  function automatic void clip_axis(input longint c, input longint s,
                                    output longint nc, output longint ns);
    longint e1;
    longint e2;
    longint sz;
    e1 = 2 * c - s;
    e2 = 2 * c + s;
    if (clip_on && (e1 < 0 || e2 > UNIT2)) begin
      if (e1 < 0) e1 = 0;
      if (e2 > UNIT2) e2 = UNIT2;
      sz = round_shr(e2 - e1, 1);
      nc = round_shr(e1 + e2, 2);
      ns = (sz < 0) ? 0 : sz;
    end else begin
      nc = c;
      ns = s;
    end
  endfunction

  // scale one axis to pixels; origin uses the unsaturated pixel size
  function automatic void scale_axis(input longint c, input longint s, input longint dim,
                                     output longint org, output longint size);
    longint sp;
    sp   = round_shr(s * dim, FRAC);
    org  = clamp(round_shr(2 * c * dim - sp * (longint'(1) <<< FRAC), FRAC + 1),
                 -16384, 16383);
    size = clamp(sp, 0, 16383);
  endfunction

  // fold one accepted class word into the running state; close the detection on tlast
  task automatic track_class(input logic [IN_DW-1:0] data, input logic last);
    logic [PROB_W-1:0] p;
    longint ncx, ncy, nw, nh, rx, ry, rw, rh;
    det_result_t r;
    p = data[0 +: PROB_W];
    n_words++;
    if (p >= thr) begin
      if (hit_cnt < 511) hit_cnt++;
      if (p > best_p) begin
        best_p   = p;
        best_idx = cls_idx;
      end
    end
    if (cls_idx < NUM_CLASSES - 1) cls_idx++;
    if (last) begin
      n_dets++;
      if (best_p >= thr) begin
        clip_axis(longint'($signed(data[I_CX +: CX_W])), longint'(data[I_W +: SZ_W]), ncx, nw);
        clip_axis(longint'($signed(data[I_CY +: CX_W])), longint'(data[I_H +: SZ_W]), ncy, nh);
        ncx = clamp(ncx, -131072, 131071);
        ncy = clamp(ncy, -131072, 131071);
        nw  = clamp(nw, 0, 131071);
        nh  = clamp(nh, 0, 131071);
        scale_axis(ncx, nw, longint'(img_w), rx, rw);
        scale_axis(ncy, nh, longint'(img_h), ry, rh);
        r.cls  = best_idx[IDX_W-1:0];
        r.prob = best_p;
        r.hits = hit_cnt[HIT_W-1:0];
        r.rx   = rx[PXO_W-1:0];
        r.ry   = ry[PXO_W-1:0];
        r.rw   = rw[PXS_W-1:0];
        r.rh   = rh[PXS_W-1:0];
        r.ncx  = ncx[CX_W-1:0];
        r.ncy  = ncy[CX_W-1:0];
        r.nw   = nw[SZ_W-1:0];
        r.nh   = nh[SZ_W-1:0];
        due_detections.insert(due_detections.size(), r);
      end
      cls_idx  = 0;
      best_idx = 0;
      best_p   = '0;
      hit_cnt  = 0;
    end
  endtask

  // ------------------------------------------------------------------ checking

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_detection();
    det_result_t want;
    if (due_detections.size() == 0) begin
      $display("%0t ns: unexpected detection word, expected none, got 0x%0h",
               $time, out_tdata);
      errors++;
    end else begin
      want = due_detections.pop_front();
      n_checked++;
      check_field("top_class", 32'(want.cls),  32'(out_tdata[0      +: IDX_W]));
      check_field("best_prob", 32'(want.prob), 32'(out_tdata[O_PROB +: PROB_W]));
      check_field("hit_count", 32'(want.hits), 32'(out_tdata[O_HIT  +: HIT_W]));
      check_field("rect_x",    32'(want.rx),   32'(out_tdata[O_RX   +: PXO_W]));
      check_field("rect_y",    32'(want.ry),   32'(out_tdata[O_RY   +: PXO_W]));
      check_field("rect_w",    32'(want.rw),   32'(out_tdata[O_RW   +: PXS_W]));
      check_field("rect_h",    32'(want.rh),   32'(out_tdata[O_RH   +: PXS_W]));
      check_field("norm_cx",   32'(want.ncx),  32'(out_tdata[O_NCX  +: CX_W]));
      check_field("norm_cy",   32'(want.ncy),  32'(out_tdata[O_NCY  +: CX_W]));
      check_field("norm_w",    32'(want.nw),   32'(out_tdata[O_NW   +: SZ_W]));
      check_field("norm_h",    32'(want.nh),   32'(out_tdata[O_NH   +: SZ_W]));
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) check_detection();
      if (in_tvalid && in_tready) track_class(in_tdata, in_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t ns: no word moved for %0d cycles, %0d detections outstanding",
               $time, WATCHDOG, due_detections.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------------ driving

  class_word_t drv_word;
  int          burst_left = 0;
  int          gap_left   = 0;

  // send words in bursts with random gaps; hold a word until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
        drv_word = pending_words.pop_front();
        in_tdata  <= IN_DW'({drv_word.h, drv_word.w, drv_word.cy, drv_word.cx,
                             drv_word.prob});
        in_tlast  <= drv_word.last;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  int stall_mode = 0;
  int mode_left  = 0;

  // receiver: switch between always ready, random gaps and long stalls
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(64, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_tready <= ($urandom_range(0, 15) == 0) ? ~out_tready : out_tready;
      end
    endcase
  end

  // ------------------------------------------------------------------ stimulus

  task automatic add_word(input int prob, input bit last, input int cx, input int cy,
                          input int w, input int h);
    class_word_t cw;
    cw.prob = prob[PROB_W-1:0];
    cw.last = last;
    cw.cx   = cx[CX_W-1:0];
    cw.cy   = cy[CX_W-1:0];
    cw.w    = w[SZ_W-1:0];
    cw.h    = h[SZ_W-1:0];
    pending_words.insert(pending_words.size(), cw);
  endtask

  // probabilities biased towards the extremes and the threshold itself
  function automatic int rand_prob();
    case ($urandom_range(0, 7))
      0: return 65536;
      1: return 0;
      2: return int'(thr);
      3: return (thr == 0) ? 0 : int'(thr) - 1;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // mostly plausible boxes, the rest raw bits
  task automatic rand_box(output int cx, output int cy, output int w, output int h);
    if ($urandom_range(0, 3) != 0) begin
      cx = $urandom_range(0, 98304) - 16384;
      cy = $urandom_range(0, 98304) - 16384;
      w  = $urandom_range(0, 80000);
      h  = $urandom_range(0, 80000);
    end else begin
      cx = $urandom;
      cy = $urandom;
      w  = $urandom;
      h  = $urandom;
    end
  endtask

  task automatic add_detection(input int len);
    int cx, cy, w, h;
    for (int i = 0; i < len; i++) begin
      rand_box(cx, cy, w, h);
      add_word(rand_prob(), i == len - 1, cx, cy, w, h);
    end
  endtask

  // long detection: the best class lies past the index cap
  task automatic add_long_detection(input int len);
    int cx, cy, w, h;
    for (int i = 0; i < len; i++) begin
      rand_box(cx, cy, w, h);
      add_word((i == 400) ? 65536 : $urandom_range(0, 65535), i == len - 1, cx, cy, w, h);
    end
  endtask

  task automatic random_phase(input int n_items);
    int pushed;
    int len;
    pushed = 0;
    while (pushed < n_items) begin
      len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
      add_detection(len);
      pushed += len;
    end
  endtask

  // hold the sender until every detection is out and the pipeline has emptied
  task automatic wait_drain();
    while (pending_words.size() != 0 || in_tvalid || due_detections.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_THRESH: thr     = val[PROB_W-1:0];
      REG_CLIP:   clip_on = val[0];
      REG_WIDTH:  img_w   = val[DIM_W-1:0];
      REG_HEIGHT: img_h   = val[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int threshold, input int clip, input int width,
                            input int height);
    wait_drain();
    write_reg(REG_THRESH, threshold);
    write_reg(REG_CLIP, clip);
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
    n_settings++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: plain box, no-hit detection, tie between classes
    add_word(65536, 1, 32768, 32768, 32768, 32768);
    add_word(0, 1, 32768, 32768, 32768, 32768);
    add_word(40000, 0, 0, 0, 0, 0);
    add_word(50000, 0, 0, 0, 0, 0);
    add_word(50000, 0, 0, 0, 0, 0);
    add_word(30000, 1, 0, 65536, 65536, 65536);
    // probability exactly at threshold, box fields at their extremes
    add_word(32768, 1, -131072, 131071, 131071, 0);
    add_word(65535, 0, 0, 0, 0, 0);
    add_word(65536, 1, 131071, -131072, 0, 131071);
    // clamped edges cross on both axes
    add_word(50000, 1, -65536, 131071, 0, 0);

    // clipping off
    set_config(32768, 0, 640, 480);
    add_word(65536, 1, -131072, 131071, 131071, 131071);

    // zero threshold: all-zero detections still report
    set_config(0, 1, 640, 480);
    add_word(0, 0, 0, 0, 0, 0);
    add_word(0, 0, 0, 0, 0, 0);
    add_word(0, 1, 16384, 16384, 8192, 8192);
    add_word(0, 1, 65536, 0, 65536, 32768);

    // full-scale threshold
    set_config(65536, 1, 640, 480);
    add_word(65535, 1, 32768, 32768, 32768, 32768);
    add_word(65536, 0, 0, 0, 0, 0);
    add_word(65536, 1, 32768, 32768, 32768, 32768);

    // pixel outputs driven into saturation
    set_config(32768, 0, 16383, 8192);
    add_word(65536, 1, 131071, -131072, 131071, 131071);

    // zero image width
    set_config(32768, 1, 0, 1);
    add_word(65536, 1, 40000, 20000, 30000, 50000);

    // random detections over a spread of settings
    set_config(32768, 1, 640, 480);
    random_phase(50);
    set_config(0, 1, 8192, 8192);
    add_long_detection(515);
    random_phase(40);
    set_config(65536, 0, 1, 1);
    random_phase(50);
    set_config(1, 1, 16383, 16383);
    random_phase(50);
    repeat (4) begin
      set_config($urandom_range(0, 65536), $urandom_range(0, 1), $urandom_range(1, 8192),
                 $urandom_range(1, 8192));
      random_phase(50);
    end
    set_config($urandom_range(0, 65536), 0, 0, 0);
    random_phase(40);

    wait_drain();
    $display("Sent %0d class words in %0d detections over %0d register settings;",
             n_words, n_dets, n_settings + 1);
    $display("checked %0d detections, with %0d field mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
